@@ sv/jwrs_pkg.sv @@
// Package for the jagged wipe row span generator.
// Holds widths, register indexes, pipeline sizes and the gradient step function.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package jwrs_pkg;

  // Field widths.
  localparam int unsigned SCREEN_W  = 12;
  localparam int unsigned GRAD_W    = 10;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned RAND_W    = 15;
  localparam int unsigned LEVEL_W   = 21;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 16;

  // Largest usable screen width.
  localparam logic [SCREEN_W-1:0] MAX_SCREEN_WIDTH = 12'd4095;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_WIDTH = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GRAD_ENABLE  = 4'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GRAD_WIDTH   = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_COUNT_MAX    = 4'd3;

  // Reset values of the configuration registers.
  localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST = 12'd640;
  localparam logic [COUNT_W-1:0]  COUNT_MAX_RST    = 16'd1;

  // Start edge scales by W/32768, end edge by W/65536.
  localparam int unsigned START_SHIFT = 15;
  localparam int unsigned END_SHIFT   = 16;

  // Products of the edge stage.
  localparam int unsigned EDGE_PROD_W = RAND_W + SCREEN_W;
  localparam int unsigned START_MAG_W = 13;   // start edge magnitude, at most 5117
  localparam int unsigned SPAN_W      = 14;   // end minus start, at most 11259

  // Interpolation divider sizes.
  localparam int unsigned NUM_W      = SPAN_W + COUNT_W;
  localparam int unsigned DEN_W      = COUNT_W;
  localparam int unsigned TAG_W      = START_MAG_W;
  localparam int unsigned DIV_STEPS  = 2;
  localparam int unsigned DIV_STAGES = NUM_W / DIV_STEPS;

  // Edge position width (signed) and request to result latency.
  localparam int unsigned POS_W   = NUM_W + 1;
  localparam int unsigned LATENCY = DIV_STAGES + 5;

  // Gradient levels.
  localparam int unsigned DELTA_W = 9;
  localparam logic [DELTA_W-1:0] GRAD_DELTA_ZERO = 9'd4;
  localparam logic signed [LEVEL_W+3:0] LEVEL_FULL = 25'sd256;
  localparam logic signed [LEVEL_W+3:0] LEVEL_MIN  = -25'sd1048576;

  // Gradient step per pixel: 256 divided by the band width, truncated.
  // A band width of zero uses a fixed step.
  function automatic logic [DELTA_W-1:0] grad_delta(input logic [GRAD_W-1:0] g);
    logic [DELTA_W-1:0] r;
    case (g) inside
      10'd0:             r = GRAD_DELTA_ZERO;
      10'd1:             r = 9'd256;
      10'd2:             r = 9'd128;
      10'd3:             r = 9'd85;
      10'd4:             r = 9'd64;
      10'd5:             r = 9'd51;
      10'd6:             r = 9'd42;
      10'd7:             r = 9'd36;
      10'd8:             r = 9'd32;
      10'd9:             r = 9'd28;
      10'd10:            r = 9'd25;
      10'd11:            r = 9'd23;
      10'd12:            r = 9'd21;
      10'd13:            r = 9'd19;
      10'd14:            r = 9'd18;
      10'd15:            r = 9'd17;
      10'd16:            r = 9'd16;
      10'd17:            r = 9'd15;
      10'd18:            r = 9'd14;
      10'd19:            r = 9'd13;
      [10'd20:10'd21]:   r = 9'd12;
      [10'd22:10'd23]:   r = 9'd11;
      [10'd24:10'd25]:   r = 9'd10;
      [10'd26:10'd28]:   r = 9'd9;
      [10'd29:10'd32]:   r = 9'd8;
      [10'd33:10'd36]:   r = 9'd7;
      [10'd37:10'd42]:   r = 9'd6;
      [10'd43:10'd51]:   r = 9'd5;
      [10'd52:10'd64]:   r = 9'd4;
      [10'd65:10'd85]:   r = 9'd3;
      [10'd86:10'd128]:  r = 9'd2;
      [10'd129:10'd256]: r = 9'd1;
      default:           r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/jwrs_div.sv @@
// Pipelined restoring divider for the edge interpolation of the row span generator.
// Retires DIV_STEPS quotient bits per stage and carries a tag alongside each request.
// Depends on jwrs_pkg.
`timescale 1ns / 1ps

module jwrs_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_vld_i,
  input  logic [jwrs_pkg::NUM_W-1:0] in_num_i,
  input  logic [jwrs_pkg::TAG_W-1:0] in_tag_i,
  input  logic [jwrs_pkg::DEN_W-1:0] divisor_i,
  output logic                       out_vld_o,
  output logic [jwrs_pkg::NUM_W-1:0] out_quot_o,
  output logic [jwrs_pkg::TAG_W-1:0] out_tag_o
);
  import jwrs_pkg::*;

  logic [DIV_STAGES-1:0] vld_q;
  logic [DEN_W-1:0]      rem_q [DIV_STAGES];
  logic [DEN_W-1:0]      rem_d [DIV_STAGES];
  logic [NUM_W-1:0]      num_q [DIV_STAGES];
  logic [NUM_W-1:0]      num_d [DIV_STAGES];
  logic [TAG_W-1:0]      tag_q [DIV_STAGES];

  // Each stage shifts in the next dividend bits and subtracts where the divisor fits.
  // Quotient bits replace the dividend bits as they shift out.
  always_comb begin
    logic [DEN_W:0]   trial;
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] num;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        rem = '0;
        num = in_num_i;
      end else begin
        rem = rem_q[s-1];
        num = num_q[s-1];
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
        trial = {rem, num[NUM_W-1]};
        num   = {num[NUM_W-2:0], 1'b0};
        if (trial >= {1'b0, divisor_i}) begin
          rem    = DEN_W'(trial - {1'b0, divisor_i});
          num[0] = 1'b1;
        end else begin
          rem = trial[DEN_W-1:0];
        end
      end
      rem_d[s] = rem;
      num_d[s] = num;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DIV_STAGES-2:0], in_vld_i};
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      rem_q[s] <= rem_d[s];
      num_q[s] <= num_d[s];
      tag_q[s] <= (s == 0) ? in_tag_i : tag_q[(s == 0) ? 0 : s-1];
    end
  end

  assign out_vld_o  = vld_q[DIV_STAGES-1];
  assign out_quot_o = num_q[DIV_STAGES-1];
  assign out_tag_o  = tag_q[DIV_STAGES-1];

endmodule

@@ sv/jagged_wipe_row_spans_top.sv @@
// Jagged wipe row span generator: one screen row per request, fully pipelined.
// Pipeline: an accepted request passes through the edge stages, the DIV_STAGES divider
// stages, a position stage and an output stage before the result strobe rises.
// Throughput: one request per cycle; busy_o stays low, the divider stages set the depth.
// Reset (rst_ni low, asynchronous) clears all valid bits and restores register defaults.
// Depends on jwrs_pkg and jwrs_div.
`timescale 1ns / 1ps

module jagged_wipe_row_spans_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [jwrs_pkg::RAND_W-1:0]     rand_start_i,
  input  logic [jwrs_pkg::RAND_W-1:0]     rand_end_i,
  input  logic [jwrs_pkg::COUNT_W-1:0]    frame_count_i,
  output logic                            valid_o,
  output logic [jwrs_pkg::SCREEN_W-1:0]   left_run_o,
  output logic [jwrs_pkg::GRAD_W-1:0]     grad_run_o,
  output logic signed [jwrs_pkg::LEVEL_W-1:0] grad_level_o,
  output logic [jwrs_pkg::SCREEN_W-1:0]   right_run_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [jwrs_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [jwrs_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import jwrs_pkg::*;

  logic [SCREEN_W-1:0] screen_width_q;
  logic                grad_enable_q;
  logic [GRAD_W-1:0]   grad_width_q;
  logic [COUNT_W-1:0]  count_max_q;

  logic [SCREEN_W-1:0] w_eff;
  logic [COUNT_W-1:0]  cm_eff;
  logic [DELTA_W-1:0]  delta;

  logic                   s1_vld_q;
  logic [EDGE_PROD_W-1:0] s1_prod_s_q;
  logic [EDGE_PROD_W-1:0] s1_prod_e_q;
  logic [COUNT_W-1:0]     s1_cnt_q;

  logic                   s2_vld_q;
  logic [START_MAG_W-1:0] s2_mag_q;
  logic [START_MAG_W-1:0] s2_mag_d;
  logic [SPAN_W-1:0]      s2_span_q;
  logic [SPAN_W-1:0]      s2_span_d;
  logic [COUNT_W-1:0]     s2_cnt_q;

  logic                   s3_vld_q;
  logic [NUM_W-1:0]       s3_num_q;
  logic [START_MAG_W-1:0] s3_mag_q;

  logic                   div_vld;
  logic [NUM_W-1:0]       div_quot;
  logic [START_MAG_W-1:0] div_mag;

  logic                    pos_vld_q;
  logic signed [POS_W-1:0] pos_q;
  logic signed [POS_W-1:0] pos_d;

  logic signed [POS_W:0]       pos_g;
  logic [SCREEN_W-1:0]         lp;
  logic [SCREEN_W-1:0]         rp;
  logic signed [23:0]          lvl_prod;
  logic signed [LEVEL_W+3:0]   lvl_sum;
  logic signed [LEVEL_W-1:0]   level;

  logic                        valid_q;
  logic [SCREEN_W-1:0]         left_run_q;
  logic [SCREEN_W-1:0]         left_run_d;
  logic [GRAD_W-1:0]           grad_run_q;
  logic [GRAD_W-1:0]           grad_run_d;
  logic signed [LEVEL_W-1:0]   grad_level_q;
  logic signed [LEVEL_W-1:0]   grad_level_d;
  logic [SCREEN_W-1:0]         right_run_q;
  logic [SCREEN_W-1:0]         right_run_d;

  // The pipeline never stalls, so requests and register writes are always taken.
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q <= SCREEN_WIDTH_RST;
      grad_enable_q  <= 1'b0;
      grad_width_q   <= '0;
      count_max_q    <= COUNT_MAX_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_addr_i)
        REG_SCREEN_WIDTH: screen_width_q <= cfg_data_i[SCREEN_W-1:0];
        REG_GRAD_ENABLE:  grad_enable_q  <= cfg_data_i[0];
        REG_GRAD_WIDTH:   grad_width_q   <= cfg_data_i[GRAD_W-1:0];
        REG_COUNT_MAX:    count_max_q    <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective width, frame range and gradient step.
  assign w_eff  = (screen_width_q > MAX_SCREEN_WIDTH) ? MAX_SCREEN_WIDTH : screen_width_q;
  assign cm_eff = (count_max_q == '0) ? COUNT_W'(1) : count_max_q;
  assign delta  = grad_delta(grad_width_q);

  // Stage 1: scale both random words by the screen width.
  always_ff @(posedge clk_i) begin
    s1_prod_s_q <= EDGE_PROD_W'(rand_start_i) * EDGE_PROD_W'(w_eff);
    s1_prod_e_q <= EDGE_PROD_W'(rand_end_i) * EDGE_PROD_W'(w_eff);
    s1_cnt_q    <= frame_count_i;
  end

  // Stage 2: start edge magnitude (start is never positive) and span to the end edge.
  always_comb begin
    s2_mag_d = START_MAG_W'(s1_prod_s_q >> START_SHIFT)
             + (grad_enable_q ? START_MAG_W'(grad_width_q) : '0);
    s2_span_d = SPAN_W'(w_eff) + SPAN_W'(s1_prod_e_q >> END_SHIFT) + SPAN_W'(s2_mag_d);
  end

  always_ff @(posedge clk_i) begin
    s2_mag_q  <= s2_mag_d;
    s2_span_q <= s2_span_d;
    s2_cnt_q  <= s1_cnt_q;
  end

  // Stage 3: span times frame count.
  always_ff @(posedge clk_i) begin
    s3_num_q <= NUM_W'(s2_span_q) * NUM_W'(s2_cnt_q);
    s3_mag_q <= s2_mag_q;
  end

  // Front stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start_i && !busy_o;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  // Divide by the frame count at which the wipe completes.
  jwrs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (s3_vld_q),
    .in_num_i   (s3_num_q),
    .in_tag_i   (s3_mag_q),
    .divisor_i  (cm_eff),
    .out_vld_o  (div_vld),
    .out_quot_o (div_quot),
    .out_tag_o  (div_mag)
  );

  // Edge position: start edge plus the interpolated distance.
  assign pos_d = $signed({1'b0, div_quot}) - $signed(POS_W'(div_mag));

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
  end

  // Clamp the edge and the band end to the screen, and form the band start level.
  always_comb begin
    pos_g = $signed({pos_q[POS_W-1], pos_q}) + $signed((POS_W+1)'(grad_width_q));

    if (pos_q[POS_W-1]) begin
      lp = '0;
    end else if (pos_q > $signed(POS_W'(w_eff))) begin
      lp = w_eff;
    end else begin
      lp = pos_q[SCREEN_W-1:0];
    end

    if (pos_g[POS_W]) begin
      rp = '0;
    end else if (pos_g > $signed((POS_W+1)'(w_eff))) begin
      rp = w_eff;
    end else begin
      rp = pos_g[SCREEN_W-1:0];
    end

    // A negative edge is never below minus 5117, so its low bits carry the value.
    lvl_prod = $signed(pos_q[13:0]) * $signed({1'b0, delta});
    lvl_sum  = LEVEL_FULL + $signed({lvl_prod[23], lvl_prod});
    if (!pos_q[POS_W-1]) begin
      level = LEVEL_W'(LEVEL_FULL);
    end else if (lvl_sum < LEVEL_MIN) begin
      level = LEVEL_W'(LEVEL_MIN);
    end else begin
      level = lvl_sum[LEVEL_W-1:0];
    end

    left_run_d = lp;
    if (grad_enable_q) begin
      grad_run_d   = GRAD_W'(rp - lp);
      grad_level_d = level;
      right_run_d  = w_eff - rp;
    end else begin
      grad_run_d   = '0;
      grad_level_d = '0;
      right_run_d  = '0;
    end
  end

  // Output registers.
  always_ff @(posedge clk_i) begin
    left_run_q   <= left_run_d;
    grad_run_q   <= grad_run_d;
    grad_level_q <= grad_level_d;
    right_run_q  <= right_run_d;
  end

  // Back stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_vld_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      pos_vld_q <= div_vld;
      valid_q   <= pos_vld_q;
    end
  end

  assign valid_o      = valid_q;
  assign left_run_o   = left_run_q;
  assign grad_run_o   = grad_run_q;
  assign grad_level_o = grad_level_q;
  assign right_run_o  = right_run_q;

endmodule

@@ sv/jwrs_checker.sv @@
// Port level checks for the jagged wipe row span generator, bound to its top level.
// Depends on jwrs_pkg and jagged_wipe_row_spans_top.
`timescale 1ns / 1ps

module jwrs_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start_i,
  input logic                            busy_o,
  input logic                            valid_o,
  input logic [jwrs_pkg::SCREEN_W-1:0]   left_run_o,
  input logic [jwrs_pkg::GRAD_W-1:0]     grad_run_o,
  input logic signed [jwrs_pkg::LEVEL_W-1:0] grad_level_o,
  input logic [jwrs_pkg::SCREEN_W-1:0]   right_run_o
);
  import jwrs_pkg::*;

  // Every accepted request yields its result after the fixed latency.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##20 valid_o)
    else $error("request without result after the pipeline latency");

  // No result appears without a request accepted the latency earlier.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, 20))
    else $error("result strobe without a matching request");

  // The band start level never exceeds full intensity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (grad_level_o <= 21'sd256))
    else $error("gradient level above full");

  // The three runs of a row never exceed the widest screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (({1'b0, left_run_o} + {3'b000, grad_run_o} + {1'b0, right_run_o})
                 <= {1'b0, MAX_SCREEN_WIDTH}))
    else $error("row runs exceed the screen width");

endmodule

bind jagged_wipe_row_spans_top jwrs_checker u_jwrs_checker (.*);
